[src/dlp_pkg.sv]
// Shared constants and hex decode for the directory listing line parser.
`timescale 1ns / 1ps
`default_nettype none

package dlp_pkg;

   localparam int MAX_LINE = 4096;
   localparam int POS_W = $clog2(MAX_LINE);
   localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_LINE - 1);

   localparam logic [7:0] NL_BYTE = 8'h0A;
   localparam logic [7:0] SLASH_BYTE = 8'h2F;
   localparam int DIGEST_DIGITS = 32;
   localparam int SIZE_START = 33;
   localparam int SIZE_DIGITS = 8;
   localparam int NAME_START = 42;
   localparam int OFFSET_W = 6;
   localparam int NAME_LEN_W = 12;

   typedef struct packed {
      logic       ok;
      logic [3:0] value;
   } hex_digit_type;

   function automatic hex_digit_type hex_decode(input logic [7:0] c);
      hex_digit_type d;
      d.ok = 1'b1;
      d.value = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         d.value = 4'(c - 8'h30);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         d.value = 4'(c - 8'h61 + 8'd10);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         d.value = 4'(c - 8'h41 + 8'd10);
      end else begin
         d.ok = 1'b0;
      end
      return d;
   endfunction

endpackage

`default_nettype wire

[src/dir_listing_line_parser_unit.sv]
// Directory listing line parser: bytes in, one record per listing line out.
//
// Usage:
//   req_ channel carries one payload byte per transaction plus an
//   end-of-buffer flag on the last byte. A newline byte ends a line; the
//   flagged byte ends the line too when it is not a newline.
//   rsp_ channel carries one record per line: directory or file, error flag,
//   128-bit digest, hex size, name offset and name length.
//   Latency: the record for a line appears in the cycle after the
//   transaction of its ending byte. Throughput: one byte per cycle when not
//   stalled; the per-line state and hex shift registers update per byte.
//   The result register holds one record; req_ready drops while a record
//   waits and rsp_ready is low, so a stalled receiver stops the whole byte
//   stream until the waiting record is taken.
//   Reset clears the line state and the record valid flag; the next byte
//   starts a fresh line.
`timescale 1ns / 1ps
`default_nettype none

module dir_listing_line_parser_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_line_byte,
   input  wire logic        req_end_of_buffer,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_is_directory,
   output logic             rsp_parse_error,
   output logic [63:0]      rsp_digest_high,
   output logic [63:0]      rsp_digest_low,
   output logic [31:0]      rsp_file_size,
   output logic [dlp_pkg::OFFSET_W-1:0]   rsp_name_offset,
   output logic [dlp_pkg::NAME_LEN_W-1:0] rsp_name_length
);

   typedef enum logic [1:0] {
      SIZE_IDLE,
      SIZE_RUN,
      SIZE_STOP
   } size_phase_type;

   typedef struct packed {
      logic [dlp_pkg::POS_W-1:0] pos;
      logic [7:0]                prev;
      logic [63:0]               dig0;
      logic [63:0]               dig1;
      logic [31:0]               size;
      size_phase_type            phase;
      logic                      dbad;
      logic                      sbad;
      logic                      ovf;
   } line_state_type;

   localparam logic [dlp_pkg::POS_W-1:0] DIG_END = dlp_pkg::POS_W'(dlp_pkg::DIGEST_DIGITS);
   localparam logic [dlp_pkg::POS_W-1:0] SZ_FIRST = dlp_pkg::POS_W'(dlp_pkg::SIZE_START);
   localparam logic [dlp_pkg::POS_W-1:0] SZ_END =
      dlp_pkg::POS_W'(dlp_pkg::SIZE_START + dlp_pkg::SIZE_DIGITS);
   localparam logic [dlp_pkg::POS_W-1:0] NAME_POS = dlp_pkg::POS_W'(dlp_pkg::NAME_START);

   line_state_type line_ff, line_in, taken, src;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            is_dir_ff, is_dir_in;
   logic                            perr_ff, perr_in;
   logic [63:0]                     dhi_ff, dhi_in;
   logic [63:0]                     dlo_ff, dlo_in;
   logic [31:0]                     size_ff, size_in;
   logic [dlp_pkg::OFFSET_W-1:0]    noff_ff, noff_in;
   logic [dlp_pkg::NAME_LEN_W-1:0]  nlen_ff, nlen_in;

   logic                  accept;
   logic                  is_nl;
   logic                  emit;
   dlp_pkg::hex_digit_type hd;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign is_nl     = (req_line_byte == dlp_pkg::NL_BYTE);
   assign emit      = is_nl || req_end_of_buffer;
   assign hd        = dlp_pkg::hex_decode(req_line_byte);

   // line state after taking the current byte into the line
   always_comb begin
      taken = line_ff;
      if (line_ff.pos >= dlp_pkg::POS_LIMIT) begin
         taken.ovf = 1'b1;
      end else begin
         if (line_ff.pos < DIG_END) begin
            if (!hd.ok) begin
               taken.dbad = 1'b1;
            end else if (line_ff.pos[4]) begin
               taken.dig1 = {line_ff.dig1[59:0], hd.value};
            end else begin
               taken.dig0 = {line_ff.dig0[59:0], hd.value};
            end
         end else if (line_ff.pos >= SZ_FIRST && line_ff.pos < SZ_END) begin
            case (line_ff.phase)
               SIZE_IDLE: begin
                  if (!hd.ok) begin
                     taken.sbad  = 1'b1;
                     taken.phase = SIZE_STOP;
                  end else begin
                     taken.size  = {28'd0, hd.value};
                     taken.phase = SIZE_RUN;
                  end
               end
               SIZE_RUN: begin
                  if (!hd.ok) begin
                     taken.phase = SIZE_STOP;
                  end else begin
                     taken.size = {line_ff.size[27:0], hd.value};
                  end
               end
               default: ;
            endcase
         end
         taken.prev = req_line_byte;
         taken.pos  = line_ff.pos + 1'b1;
      end
   end

   // record for the line being closed; a newline is not part of the line
   always_comb begin
      src       = is_nl ? line_ff : taken;
      is_dir_in = 1'b0;
      perr_in   = 1'b0;
      dhi_in    = 64'd0;
      dlo_in    = 64'd0;
      size_in   = 32'd0;
      noff_in   = '0;
      nlen_in   = '0;
      if (src.ovf || src.pos == '0) begin
         perr_in = 1'b1;
      end else if (src.prev == dlp_pkg::SLASH_BYTE) begin
         is_dir_in = 1'b1;
         nlen_in   = dlp_pkg::NAME_LEN_W'(src.pos - 1'b1);
      end else if (src.pos < NAME_POS || src.dbad || src.sbad) begin
         perr_in = 1'b1;
      end else begin
         dhi_in  = src.dig0;
         dlo_in  = src.dig1;
         size_in = src.size;
         noff_in = dlp_pkg::OFFSET_W'(dlp_pkg::NAME_START);
         nlen_in = dlp_pkg::NAME_LEN_W'(src.pos - NAME_POS);
      end
   end

   always_comb begin
      line_in = line_ff;
      if (accept) begin
         if (emit) begin
            line_in = '{pos: '0, prev: 8'd0, dig0: 64'd0, dig1: 64'd0, size: 32'd0,
                        phase: SIZE_IDLE, dbad: 1'b0, sbad: 1'b0, ovf: 1'b0};
         end else begin
            line_in = taken;
         end
      end
      rsp_valid_in = accept ? emit : (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_ff <= '{pos: '0, prev: 8'd0, dig0: 64'd0, dig1: 64'd0, size: 32'd0,
                      phase: SIZE_IDLE, dbad: 1'b0, sbad: 1'b0, ovf: 1'b0};
         rsp_valid_ff <= 1'b0;
      end else begin
         line_ff      <= line_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept && emit) begin
         is_dir_ff <= is_dir_in;
         perr_ff   <= perr_in;
         dhi_ff    <= dhi_in;
         dlo_ff    <= dlo_in;
         size_ff   <= size_in;
         noff_ff   <= noff_in;
         nlen_ff   <= nlen_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_is_directory = is_dir_ff;
   assign rsp_parse_error  = perr_ff;
   assign rsp_digest_high  = dhi_ff;
   assign rsp_digest_low   = dlo_ff;
   assign rsp_file_size    = size_ff;
   assign rsp_name_offset  = noff_ff;
   assign rsp_name_length  = nlen_ff;

   a_err_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_parse_error |-> !rsp_is_directory && rsp_digest_high == 64'd0 &&
         rsp_digest_low == 64'd0 && rsp_file_size == 32'd0 && rsp_name_offset == '0 &&
         rsp_name_length == '0)
      else $error("error record carries nonzero fields");

   a_dir_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_directory |-> rsp_digest_high == 64'd0 &&
         rsp_digest_low == 64'd0 && rsp_file_size == 32'd0 && rsp_name_offset == '0)
      else $error("directory record carries digest, size or offset");

   a_file_offset: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_directory && !rsp_parse_error |->
         rsp_name_offset == dlp_pkg::OFFSET_W'(dlp_pkg::NAME_START))
      else $error("file record with wrong name offset");

   a_line_end: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_line_byte == dlp_pkg::NL_BYTE || req_end_of_buffer)
         |=> rsp_valid)
      else $error("line end without a record");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_line_byte != dlp_pkg::NL_BYTE && !req_end_of_buffer
         |=> !rsp_valid)
      else $error("record without a line end");

endmodule

`default_nettype wire

[tb/testbench.sv]
// Self-checking testbench for the directory listing line parser.
`timescale 1ns / 1ps

module testbench;

   localparam int CYCLE_LIMIT = 400000;
   localparam int RSP_HOLD_CYCLES = 300;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } payload_byte_type;

   typedef struct packed {
      logic                           is_directory;
      logic                           parse_error;
      logic [63:0]                    digest_high;
      logic [63:0]                    digest_low;
      logic [31:0]                    file_size;
      logic [dlp_pkg::OFFSET_W-1:0]   name_offset;
      logic [dlp_pkg::NAME_LEN_W-1:0] name_length;
   } listing_record_type;

   typedef enum logic [1:0] {SCAN_IDLE, SCAN_DIGITS, SCAN_STOPPED} size_scan_type;
   typedef enum {LINE_NL, LINE_EOB, LINE_NL_EOB} line_end_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_line_byte = 8'h00;
   logic        req_end_of_buffer = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_is_directory;
   logic        rsp_parse_error;
   logic [63:0] rsp_digest_high;
   logic [63:0] rsp_digest_low;
   logic [31:0] rsp_file_size;
   logic [dlp_pkg::OFFSET_W-1:0]   rsp_name_offset;
   logic [dlp_pkg::NAME_LEN_W-1:0] rsp_name_length;

   payload_byte_type   pending_bytes[$];
   listing_record_type expected_records[$];
   logic [7:0]         line_bytes[$];

   // line parse state mirrored from the block
   int            cur_line_len = 0;
   logic [7:0]    cur_last_byte = 8'h00;
   logic [63:0]   cur_digest[2] = '{64'd0, 64'd0};
   logic [31:0]   cur_size = 32'd0;
   size_scan_type cur_size_scan = SCAN_IDLE;
   logic          cur_digest_bad = 1'b0;
   logic          cur_size_bad = 1'b0;
   logic          cur_overflow = 1'b0;

   int send_idle_pct = 11;
   int recv_idle_pct = 59;
   int hold_requests = 0;
   int hold_left = 0;
   int holds_taken = 0;
   int mismatch_count = 0;
   int records_seen = 0;
   int cycle_count = 0;
   int queued_bytes = 0;
   int queued_lines = 0;

   dir_listing_line_parser_unit i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_line_byte     (req_line_byte),
      .req_end_of_buffer (req_end_of_buffer),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_is_directory  (rsp_is_directory),
      .rsp_parse_error   (rsp_parse_error),
      .rsp_digest_high   (rsp_digest_high),
      .rsp_digest_low    (rsp_digest_low),
      .rsp_file_size     (rsp_file_size),
      .rsp_name_offset   (rsp_name_offset),
      .rsp_name_length   (rsp_name_length)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic int hex_nibble(input logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);
      if (c >= 8'h61 && c <= 8'h66) return int'(c - 8'h61) + 10;
      if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h41) + 10;
      return -1;
   endfunction

   // ---------------------------------------------------------------- prediction

   task automatic finish_listing_line();
      listing_record_type rec;
      rec = '0;
      if (cur_overflow || cur_line_len == 0) begin
         rec.parse_error = 1'b1;
      end else if (cur_last_byte == dlp_pkg::SLASH_BYTE) begin
         rec.is_directory = 1'b1;
         rec.name_length = dlp_pkg::NAME_LEN_W'(cur_line_len - 1);
      end else if (cur_line_len < dlp_pkg::NAME_START || cur_digest_bad || cur_size_bad) begin
         rec.parse_error = 1'b1;
      end else begin
         rec.digest_high = cur_digest[0];
         rec.digest_low = cur_digest[1];
         rec.file_size = cur_size;
         rec.name_offset = dlp_pkg::OFFSET_W'(dlp_pkg::NAME_START);
         rec.name_length = dlp_pkg::NAME_LEN_W'(cur_line_len - dlp_pkg::NAME_START);
      end
      expected_records.insert(expected_records.size(), rec);
      cur_line_len = 0;
      cur_last_byte = 8'h00;
      cur_digest[0] = 64'd0;
      cur_digest[1] = 64'd0;
      cur_size = 32'd0;
      cur_size_scan = SCAN_IDLE;
      cur_digest_bad = 1'b0;
      cur_size_bad = 1'b0;
      cur_overflow = 1'b0;
   endtask

   task automatic parse_listing_byte(input logic [7:0] b, input logic eob);
      int h;
      int k;
      if (b == dlp_pkg::NL_BYTE) begin
         finish_listing_line();
      end else begin
         h = hex_nibble(b);
         if (cur_line_len >= dlp_pkg::MAX_LINE - 1) begin
            cur_overflow = 1'b1;
         end else begin
            if (cur_line_len < dlp_pkg::DIGEST_DIGITS) begin
               k = cur_line_len / 16;
               if (h < 0) cur_digest_bad = 1'b1;
               else cur_digest[k] = {cur_digest[k][59:0], 4'(h)};
            end else if (cur_line_len >= dlp_pkg::SIZE_START
                         && cur_line_len < dlp_pkg::SIZE_START + dlp_pkg::SIZE_DIGITS) begin
               case (cur_size_scan)
                  SCAN_IDLE: begin
                     if (h < 0) begin
                        cur_size_bad = 1'b1;
                        cur_size_scan = SCAN_STOPPED;
                     end else begin
                        cur_size = 32'(h);
                        cur_size_scan = SCAN_DIGITS;
                     end
                  end
                  SCAN_DIGITS: begin
                     if (h < 0) cur_size_scan = SCAN_STOPPED;
                     else cur_size = {cur_size[27:0], 4'(h)};
                  end
                  default: ;
               endcase
            end
            cur_last_byte = b;
            cur_line_len++;
         end
         if (eob) finish_listing_line();
      end
   endtask

   // ---------------------------------------------------------------- driver

   always @(posedge clock) begin : req_driver
      payload_byte_type next_item;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) parse_listing_byte(req_line_byte, req_end_of_buffer);
         if (!req_valid || req_ready) begin
            if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_item = pending_bytes.pop_front();
               req_valid <= 1'b1;
               req_line_byte <= next_item.data;
               req_end_of_buffer <= next_item.last;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------- receiver

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left <= 0;
         holds_taken <= 0;
      end else if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (holds_taken != hold_requests) begin
         rsp_ready <= 1'b0;
         hold_left <= RSP_HOLD_CYCLES;
         holds_taken <= holds_taken + 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic check_field(input string field_name, input logic [63:0] got,
                              input logic [63:0] want);
      if (got !== want) begin
         if (mismatch_count < 10)
            $display("record %0d: %s got %h expected %h", records_seen, field_name, got, want);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin : rsp_monitor
      listing_record_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_records.size() == 0) begin
            if (mismatch_count < 10)
               $display("record %0d arrived with no line pending", records_seen);
            mismatch_count++;
         end else begin
            want = expected_records.pop_front();
            check_field("is_directory", 64'(rsp_is_directory), 64'(want.is_directory));
            check_field("parse_error", 64'(rsp_parse_error), 64'(want.parse_error));
            check_field("digest_high", rsp_digest_high, want.digest_high);
            check_field("digest_low", rsp_digest_low, want.digest_low);
            check_field("file_size", 64'(rsp_file_size), 64'(want.file_size));
            check_field("name_offset", 64'(rsp_name_offset), 64'(want.name_offset));
            check_field("name_length", 64'(rsp_name_length), 64'(want.name_length));
         end
         records_seen++;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("[dir_listing_line_parser_unit] ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------- stimulus

   function automatic logic [7:0] rand_hex_char();
      logic [3:0] v;
      v = 4'($urandom_range(15));
      if (v < 4'd10) return 8'h30 + 8'(v);
      return ($urandom_range(1) ? 8'h61 : 8'h41) + 8'(v) - 8'd10;
   endfunction

   function automatic logic [7:0] rand_non_hex();
      logic [7:0] c;
      do c = 8'($urandom_range(255)); while (hex_nibble(c) >= 0 || c == dlp_pkg::NL_BYTE);
      return c;
   endfunction

   function automatic logic [7:0] rand_name_byte();
      logic [7:0] c;
      do c = 8'($urandom_range(255)); while (c == dlp_pkg::NL_BYTE);
      return c;
   endfunction

   task automatic add_line_byte(input logic [7:0] b);
      line_bytes.insert(line_bytes.size(), b);
   endtask

   // size_digits of 0 puts a non-hex byte at the start of the size field
   task automatic build_file_line(input bit bad_digest, input int size_digits,
                                  input int name_len);
      line_bytes.delete();
      for (int i = 0; i < dlp_pkg::DIGEST_DIGITS; i++) add_line_byte(rand_hex_char());
      if (bad_digest) line_bytes[$urandom_range(dlp_pkg::DIGEST_DIGITS - 1)] = rand_non_hex();
      add_line_byte(rand_name_byte());
      for (int i = 0; i < dlp_pkg::SIZE_DIGITS; i++) begin
         if (i < size_digits) add_line_byte(rand_hex_char());
         else if (i == size_digits) add_line_byte(rand_non_hex());
         else add_line_byte(rand_name_byte());
      end
      add_line_byte(rand_name_byte());
      for (int i = 0; i < name_len; i++) add_line_byte(rand_name_byte());
      if (line_bytes[$] == dlp_pkg::SLASH_BYTE) line_bytes[$] = 8'h2E;
   endtask

   task automatic build_dir_line(input int name_len);
      line_bytes.delete();
      for (int i = 0; i < name_len; i++) add_line_byte(rand_name_byte());
      add_line_byte(dlp_pkg::SLASH_BYTE);
   endtask

   task automatic flush_line(input line_end_type ending);
      payload_byte_type item;
      for (int i = 0; i < line_bytes.size(); i++) begin
         item.data = line_bytes[i];
         item.last = (ending == LINE_EOB && i == line_bytes.size() - 1);
         pending_bytes.insert(pending_bytes.size(), item);
      end
      if (ending != LINE_EOB || line_bytes.size() == 0) begin
         item.data = dlp_pkg::NL_BYTE;
         item.last = (ending != LINE_NL);
         pending_bytes.insert(pending_bytes.size(), item);
      end
      queued_bytes += line_bytes.size() + 1;
      queued_lines++;
   endtask

   task automatic random_line();
      int pick;
      int name_len;
      int ending;
      pick = $urandom_range(99);
      name_len = ($urandom_range(9) == 0) ? $urandom_range(100) : $urandom_range(12);
      if (pick < 55) begin
         build_file_line(1'b0, $urandom_range(1, dlp_pkg::SIZE_DIGITS), name_len);
      end else if (pick < 75) begin
         build_dir_line(name_len);
      end else if (pick < 82) begin
         build_file_line(1'b1, $urandom_range(1, dlp_pkg::SIZE_DIGITS), name_len);
      end else if (pick < 87) begin
         build_file_line(1'b0, 0, name_len);
      end else if (pick < 92) begin
         build_file_line(1'b0, $urandom_range(dlp_pkg::SIZE_DIGITS), 0);
         name_len = $urandom_range(1, dlp_pkg::NAME_START - 1);
         while (line_bytes.size() > name_len) void'(line_bytes.pop_back());
      end else begin
         line_bytes.delete();
         name_len = $urandom_range(50);
         for (int i = 0; i < name_len; i++)
            add_line_byte($urandom_range(1) ? rand_hex_char() : rand_name_byte());
      end
      ending = $urandom_range(9);
      flush_line(ending == 0 ? LINE_EOB : (ending == 1 ? LINE_NL_EOB : LINE_NL));
   endtask

   task automatic random_lines(input int byte_goal, input int line_goal);
      int first_byte;
      int first_line;
      first_byte = queued_bytes;
      first_line = queued_lines;
      while (queued_bytes - first_byte < byte_goal || queued_lines - first_line < line_goal)
         random_line();
   endtask

   task automatic wait_drained();
      while (pending_bytes.size() != 0 || req_valid || expected_records.size() != 0)
         @(posedge clock);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed lines
      line_bytes.delete();
      flush_line(LINE_NL);                      // empty line
      build_dir_line(0);
      flush_line(LINE_NL);
      build_dir_line(3);
      flush_line(LINE_NL);
      build_file_line(1'b0, 8, 5);              // all-ones digest and size
      for (int i = 0; i < dlp_pkg::DIGEST_DIGITS; i++)
         line_bytes[i] = (i % 2) ? 8'h66 : 8'h46;
      for (int i = 0; i < dlp_pkg::SIZE_DIGITS; i++)
         line_bytes[dlp_pkg::SIZE_START + i] = 8'h46;
      flush_line(LINE_NL);
      build_file_line(1'b0, 8, 0);              // all zeros, empty name, exactly 42 bytes
      for (int i = 0; i < dlp_pkg::DIGEST_DIGITS; i++) line_bytes[i] = 8'h30;
      for (int i = 0; i < dlp_pkg::SIZE_DIGITS; i++)
         line_bytes[dlp_pkg::SIZE_START + i] = 8'h30;
      flush_line(LINE_NL);
      build_file_line(1'b0, 8, 4);              // size stops after two digits
      line_bytes[dlp_pkg::SIZE_START + 2] = 8'h40;
      flush_line(LINE_NL);
      build_file_line(1'b0, 8, 4);              // bad first size byte
      line_bytes[dlp_pkg::SIZE_START] = 8'h3A;
      flush_line(LINE_NL);
      build_file_line(1'b0, 8, 4);              // bad digest digit at the last position
      line_bytes[dlp_pkg::DIGEST_DIGITS - 1] = 8'h47;
      flush_line(LINE_NL);
      build_file_line(1'b0, 8, 0);              // one byte short
      void'(line_bytes.pop_back());
      flush_line(LINE_NL);
      build_file_line(1'b0, 8, 3);              // skipped offsets hold slashes
      line_bytes[dlp_pkg::DIGEST_DIGITS] = dlp_pkg::SLASH_BYTE;
      line_bytes[dlp_pkg::NAME_START - 1] = dlp_pkg::SLASH_BYTE;
      flush_line(LINE_NL);
      build_file_line(1'b0, 5, 7);
      flush_line(LINE_EOB);
      build_file_line(1'b0, 6, 2);
      flush_line(LINE_NL_EOB);
      line_bytes.delete();
      add_line_byte(8'h78);
      flush_line(LINE_EOB);                     // single byte at end of buffer
      wait_drained();

      random_lines(40, 1);

      // long receiver stall while short lines keep coming
      hold_requests <= hold_requests + 1;
      for (int i = 0; i < 24; i++) begin
         if (i % 8 == 7) line_bytes.delete();
         else build_dir_line($urandom_range(2));
         flush_line(LINE_NL);
      end
      wait_drained();

      send_idle_pct <= 59;
      recv_idle_pct <= 11;
      random_lines(40, 1);
      wait_drained();

      send_idle_pct <= 0;
      recv_idle_pct <= 0;
      random_lines(40, 1);
      wait_drained();

      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && expected_records.size() == 0)
         $display("[dir_listing_line_parser_unit] OK");
      else
         $display("[dir_listing_line_parser_unit] ERROR");
      $finish;
   end

endmodule
